// File: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the button press classifier and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int TIME_W   = 16;
  localparam int TICKS_W  = 15;
  localparam int BUTTON_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETTLE_TICKS     = 2'd0,
    REG_LONG_PRESS_TICKS = 2'd1,
    REG_TIME_WRAP        = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2
  } press_kind_t;

  localparam logic [TICKS_W-1:0] SETTLE_TICKS_RESET     = 15'd30;
  localparam logic [TICKS_W-1:0] LONG_PRESS_TICKS_RESET = 15'd2000;
  localparam logic [TIME_W-1:0]  TIME_WRAP_RESET        = 16'd65534;

endpackage

`default_nettype wire

// File: rtl/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounce of active-low buttons with short and long press detection.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the result side keeps up. A tick item
// advances the shared time base, or at the wrap value restarts it and releases
// every button; a sample item for an in-range button updates its debounce state
// and classifies it. Each item produces exactly one result, in the cycle after
// its transfer, held in an output register; a new item is taken whenever that
// register is empty or is being drained in the same cycle. Registers are written
// through the configuration channel, which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_classifier #(
  parameter int NUM_BUTTONS = 6
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             cmd,
  input  wire logic [bpc_pkg::BUTTON_W-1:0]     button,
  input  wire logic                             level,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            press_kind,
  output logic [bpc_pkg::BUTTON_W-1:0]          button_echo
);

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int EXT_W = (IDX_W > bpc_pkg::BUTTON_W) ? IDX_W : bpc_pkg::BUTTON_W;

  logic [bpc_pkg::TICKS_W-1:0] settle_ticks;
  logic [bpc_pkg::TICKS_W-1:0] long_press_ticks;
  logic [bpc_pkg::TIME_W-1:0]  time_wrap;

  logic [bpc_pkg::TIME_W-1:0]  tick_time;
  logic                        previous_level [NUM_BUTTONS];
  logic                        stable_level   [NUM_BUTTONS];
  logic [bpc_pkg::TIME_W-1:0]  change_time    [NUM_BUTTONS];

  logic                        in_accept;
  logic [bpc_pkg::TIME_W-1:0]  tick_next;
  logic                        wrap;
  logic [EXT_W-1:0]            btn_ext;
  logic                        in_range;
  logic [IDX_W-1:0]            idx;
  logic [bpc_pkg::TIME_W-1:0]  change_next;
  logic signed [bpc_pkg::TIME_W:0] hold;
  logic                        settled;
  logic                        long_held;
  logic                        stable_next;
  logic                        prev_next;
  bpc_pkg::press_kind_t        kind;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign tick_next = tick_time + 1'b1;
  assign wrap      = tick_next >= time_wrap;

  assign btn_ext  = EXT_W'(button);
  assign in_range = (EXT_W + 1)'(btn_ext) < (EXT_W + 1)'(NUM_BUTTONS);
  assign idx      = btn_ext[IDX_W-1:0];

  always_comb begin
    change_next = (level != previous_level[idx]) ? tick_time : change_time[idx];
    hold        = {1'b0, tick_time - change_next};
    hold[bpc_pkg::TIME_W] = hold[bpc_pkg::TIME_W-1];
    settled     = hold > $signed({2'b00, settle_ticks});
    long_held   = hold > $signed({2'b00, long_press_ticks});
    stable_next = stable_level[idx];
    prev_next   = level;
    kind        = bpc_pkg::KIND_NONE;
    if (in_range && settled) begin
      if (level != stable_level[idx]) begin
        stable_next = level;
        if (level == bpc_pkg::LEVEL_RELEASED) begin
          kind = bpc_pkg::KIND_SHORT;
        end
      end else if (stable_level[idx] == bpc_pkg::LEVEL_PRESSED && long_held) begin
        kind        = bpc_pkg::KIND_LONG;
        stable_next = bpc_pkg::LEVEL_RELEASED;
        prev_next   = bpc_pkg::LEVEL_RELEASED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks     <= bpc_pkg::SETTLE_TICKS_RESET;
      long_press_ticks <= bpc_pkg::LONG_PRESS_TICKS_RESET;
      time_wrap        <= bpc_pkg::TIME_WRAP_RESET;
      tick_time        <= '0;
      out_valid        <= 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        previous_level[i] <= bpc_pkg::LEVEL_RELEASED;
        stable_level[i]   <= bpc_pkg::LEVEL_RELEASED;
        change_time[i]    <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          bpc_pkg::REG_SETTLE_TICKS:     settle_ticks     <= cfg_data[bpc_pkg::TICKS_W-1:0];
          bpc_pkg::REG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data[bpc_pkg::TICKS_W-1:0];
          bpc_pkg::REG_TIME_WRAP:        time_wrap        <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept) begin
        if (cmd == bpc_pkg::CMD_TICK) begin
          if (wrap) begin
            tick_time <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
              previous_level[i] <= bpc_pkg::LEVEL_RELEASED;
              stable_level[i]   <= bpc_pkg::LEVEL_RELEASED;
            end
          end else begin
            tick_time <= tick_next;
          end
        end else if (in_range) begin
          change_time[idx]    <= change_next;
          stable_level[idx]   <= stable_next;
          previous_level[idx] <= prev_next;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (cmd == bpc_pkg::CMD_TICK) begin
        press_kind  <= bpc_pkg::KIND_NONE;
        button_echo <= '0;
      end else begin
        press_kind  <= kind;
        button_echo <= button;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks for the button press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_checker #(
  parameter int NUM_BUTTONS = 6
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           cmd,
  input wire logic [bpc_pkg::BUTTON_W-1:0]   button,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [1:0]                     press_kind,
  input wire logic [bpc_pkg::BUTTON_W-1:0]   button_echo
);

  localparam int CMP_W = bpc_pkg::BUTTON_W + 8;

  logic in_xfer;
  logic out_of_range;

  assign in_xfer      = in_valid && in_ready;
  assign out_of_range = CMP_W'(button) >= CMP_W'(NUM_BUTTONS);

  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer && cmd == bpc_pkg::CMD_TICK |=>
      out_valid && press_kind == bpc_pkg::KIND_NONE && button_echo == '0)
    else $error("tick did not give an empty result");

  a_unused_button: assert property (@(posedge clk) disable iff (rst)
    in_xfer && cmd == bpc_pkg::CMD_SAMPLE && out_of_range |=>
      out_valid && press_kind == bpc_pkg::KIND_NONE && button_echo == $past(button))
    else $error("unused button index gave an event");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> press_kind == bpc_pkg::KIND_NONE || press_kind == bpc_pkg::KIND_SHORT ||
                  press_kind == bpc_pkg::KIND_LONG)
    else $error("undefined press kind");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(press_kind) && $stable(button_echo))
    else $error("stalled result changed");

endmodule

bind button_press_classifier bpc_checker #(.NUM_BUTTONS(NUM_BUTTONS)) u_bpc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .cmd         (cmd),
  .button      (button),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .press_kind  (press_kind),
  .button_echo (button_echo)
);

`default_nettype wire

// File: tb/button_press_classifier_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_press_classifier_checker
// Watches the channels of the button press classifier, predicts every result
// from its own copy of the debounce state and compares each result field by
// field against the oldest expected one.
// ----------------------------------------------------------------------------

module button_press_classifier_checker #(
  parameter int NUM_BUTTONS = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               cmd,
  input  logic [bpc_pkg::BUTTON_W-1:0]       button,
  input  logic                               level,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [1:0]                         press_kind,
  input  logic [bpc_pkg::BUTTON_W-1:0]       button_echo,
  output int                                 mismatches,
  output int                                 results_due
);

  typedef struct packed {
    bpc_pkg::press_kind_t              kind;
    logic [bpc_pkg::BUTTON_W-1:0]      btn;
  } outcome_t;

  logic [bpc_pkg::TICKS_W-1:0] settle_reg;
  logic [bpc_pkg::TICKS_W-1:0] long_reg;
  logic [bpc_pkg::TIME_W-1:0]  wrap_reg;

  logic [bpc_pkg::TIME_W-1:0]  tick_count;
  logic                        prev_lvl   [NUM_BUTTONS];
  logic                        stable_lvl [NUM_BUTTONS];
  logic [bpc_pkg::TIME_W-1:0]  changed_at [NUM_BUTTONS];

  outcome_t           expected_q [$];
  outcome_t           want;

  function automatic void release_buttons();
    foreach (prev_lvl[i]) begin
      prev_lvl[i]   = bpc_pkg::LEVEL_RELEASED;
      stable_lvl[i] = bpc_pkg::LEVEL_RELEASED;
    end
  endfunction

  function automatic outcome_t classify_press(input logic c,
                                              input logic [bpc_pkg::BUTTON_W-1:0] b,
                                              input logic l);
    outcome_t                           res;
    logic signed [bpc_pkg::TIME_W-1:0]  hold;
    logic                               lv;
    res.kind = bpc_pkg::KIND_NONE;
    res.btn  = '0;
    if (c == bpc_pkg::CMD_TICK) begin
      tick_count = tick_count + 1'b1;
      if (tick_count >= wrap_reg) begin
        tick_count = '0;
        release_buttons();
      end
      return res;
    end
    res.btn = b;
    if (b < NUM_BUTTONS) begin
      lv = l;
      if (lv != prev_lvl[b]) begin
        changed_at[b] = tick_count;
      end
      hold = tick_count - changed_at[b];
      if (int'(hold) > int'(settle_reg)) begin
        if (lv != stable_lvl[b]) begin
          stable_lvl[b] = lv;
          if (lv == bpc_pkg::LEVEL_RELEASED) begin
            res.kind = bpc_pkg::KIND_SHORT;
          end
        end else if (stable_lvl[b] == bpc_pkg::LEVEL_PRESSED &&
                     int'(hold) > int'(long_reg)) begin
          res.kind      = bpc_pkg::KIND_LONG;
          stable_lvl[b] = bpc_pkg::LEVEL_RELEASED;
          lv            = bpc_pkg::LEVEL_RELEASED;
        end
      end
      prev_lvl[b] = lv;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      settle_reg = bpc_pkg::SETTLE_TICKS_RESET;
      long_reg   = bpc_pkg::LONG_PRESS_TICKS_RESET;
      wrap_reg   = bpc_pkg::TIME_WRAP_RESET;
      tick_count = '0;
      release_buttons();
      foreach (changed_at[i]) begin
        changed_at[i] = '0;
      end
      expected_q.delete();
      mismatches = 0;
      results_due <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bpc_pkg::REG_SETTLE_TICKS:     settle_reg = cfg_data[bpc_pkg::TICKS_W-1:0];
          bpc_pkg::REG_LONG_PRESS_TICKS: long_reg   = cfg_data[bpc_pkg::TICKS_W-1:0];
          bpc_pkg::REG_TIME_WRAP:        wrap_reg   = cfg_data[bpc_pkg::TIME_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: expected none, got kind %0d button %0d",
                     press_kind, button_echo);
          end
        end else begin
          want = expected_q.pop_front();
          if (press_kind !== want.kind || button_echo !== want.btn) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected kind %0d button %0d, got kind %0d button %0d",
                       want.kind, want.btn, press_kind, button_echo);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_q.push_back(classify_press(cmd, button, level));
      end
      results_due <= expected_q.size();
    end
  end

endmodule

// File: tb/button_press_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_press_classifier_tb
// Drives tick and button sample transfers into the button press classifier
// with random gaps and output stalls, runs a short directed sequence and then
// random phases under changing debounce settings, and reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------

module button_press_classifier_tb;

  localparam int NUM_BUTTONS = 6;
  localparam logic [bpc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                            clk;
  logic                            rst        = 1'b1;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                            in_valid   = 1'b0;
  logic                            in_ready;
  logic                            cmd        = bpc_pkg::CMD_TICK;
  logic [bpc_pkg::BUTTON_W-1:0]    button     = '0;
  logic                            level      = bpc_pkg::LEVEL_RELEASED;
  logic                            out_valid;
  logic                            out_ready  = 1'b0;
  logic [1:0]                      press_kind;
  logic [bpc_pkg::BUTTON_W-1:0]    button_echo;
  int                              mismatches;
  int                              results_due;

  logic                   calm_in    = 1'b0;
  logic                   calm_out   = 1'b0;
  int                     stall_left = 0;
  logic                   intent [NUM_BUTTONS];

  button_press_classifier #(.NUM_BUTTONS(NUM_BUTTONS)) u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .button(button), .level(level),
    .out_valid(out_valid), .out_ready(out_ready),
    .press_kind(press_kind), .button_echo(button_echo)
  );

  button_press_classifier_checker #(.NUM_BUTTONS(NUM_BUTTONS)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .button(button), .level(level),
    .out_valid(out_valid), .out_ready(out_ready),
    .press_kind(press_kind), .button_echo(button_echo),
    .mismatches(mismatches), .results_due(results_due)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap(input logic calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) calm_out = ~calm_out;
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap(calm_out);
    end
  end

  task automatic send_item(input logic c, input logic [bpc_pkg::BUTTON_W-1:0] b,
                           input logic l);
    int gap;
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    button   <= b;
    level    <= l;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic random_item();
    logic [bpc_pkg::BUTTON_W-1:0] b;
    logic                         l;
    int                           r;
    if ($urandom_range(0, 63) == 0) calm_in = ~calm_in;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      send_item(bpc_pkg::CMD_TICK, 3'($urandom), 1'($urandom));
    end else if (r < 40) begin
      send_item(bpc_pkg::CMD_SAMPLE, 3'($urandom), 1'($urandom));
    end else begin
      b = 3'($urandom_range(0, NUM_BUTTONS - 1));
      if ($urandom_range(0, 15) == 0) intent[b] = ~intent[b];
      l = intent[b];
      // bounce
      if ($urandom_range(0, 9) == 0) l = ~l;
      send_item(bpc_pkg::CMD_SAMPLE, b, l);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [bpc_pkg::CFG_DATA_W-1:0] settle_v,
                            input logic [bpc_pkg::CFG_DATA_W-1:0] long_v,
                            input logic [bpc_pkg::CFG_DATA_W-1:0] wrap_v,
                            input logic poke_spare);
    logic [bpc_pkg::CFG_IDX_W-1:0]  idx [4];
    logic [bpc_pkg::CFG_DATA_W-1:0] val [4];
    int                             n;
    idx = '{bpc_pkg::REG_SETTLE_TICKS, bpc_pkg::REG_LONG_PRESS_TICKS,
            bpc_pkg::REG_TIME_WRAP, REG_SPARE};
    val = '{settle_v, long_v, wrap_v, 16'($urandom)};
    n = poke_spare ? 4 : 3;
    cfg_valid <= 1'b1;
    for (int k = 0; k < n; k++) begin
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int s;
    foreach (intent[i]) intent[i] = bpc_pkg::LEVEL_RELEASED;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    set_config(16'd1, 16'd3, 16'd12, 1'b0);
    send_item(bpc_pkg::CMD_SAMPLE, 3'd0, bpc_pkg::LEVEL_PRESSED);
    send_item(bpc_pkg::CMD_TICK, 3'd7, bpc_pkg::LEVEL_RELEASED);
    send_item(bpc_pkg::CMD_TICK, 3'd0, bpc_pkg::LEVEL_PRESSED);
    send_item(bpc_pkg::CMD_SAMPLE, 3'd0, bpc_pkg::LEVEL_PRESSED);
    send_item(bpc_pkg::CMD_SAMPLE, 3'd0, bpc_pkg::LEVEL_RELEASED);
    repeat (2) send_item(bpc_pkg::CMD_TICK, 3'd0, bpc_pkg::LEVEL_PRESSED);
    send_item(bpc_pkg::CMD_SAMPLE, 3'd0, bpc_pkg::LEVEL_RELEASED);
    send_item(bpc_pkg::CMD_SAMPLE, 3'd5, bpc_pkg::LEVEL_PRESSED);
    repeat (3) send_item(bpc_pkg::CMD_TICK, 3'd0, bpc_pkg::LEVEL_PRESSED);
    send_item(bpc_pkg::CMD_SAMPLE, 3'd5, bpc_pkg::LEVEL_PRESSED);
    send_item(bpc_pkg::CMD_TICK, 3'd0, bpc_pkg::LEVEL_PRESSED);
    send_item(bpc_pkg::CMD_SAMPLE, 3'd5, bpc_pkg::LEVEL_PRESSED);
    send_item(bpc_pkg::CMD_SAMPLE, 3'd5, bpc_pkg::LEVEL_PRESSED);
    send_item(bpc_pkg::CMD_SAMPLE, 3'd7, bpc_pkg::LEVEL_PRESSED);
    send_item(bpc_pkg::CMD_SAMPLE, 3'd6, bpc_pkg::LEVEL_RELEASED);
    repeat (4) send_item(bpc_pkg::CMD_TICK, 3'd0, bpc_pkg::LEVEL_PRESSED);
    send_item(bpc_pkg::CMD_SAMPLE, 3'd5, bpc_pkg::LEVEL_RELEASED);
    send_item(bpc_pkg::CMD_SAMPLE, 3'd4, bpc_pkg::LEVEL_PRESSED);

    for (int p = 0; p < 10; p++) begin
      wait_idle();
      s = $urandom_range(0, 6);
      case (p)
        2: set_config(16'h0000, 16'h0000, 16'($urandom_range(100, 600)), 1'b0);
        4: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        6: set_config(16'($urandom_range(0, 4)), 16'h7FFF, 16'h0000, 1'b0);
        7: set_config(16'h8000, 16'h0001, 16'h0001, 1'b0);
        9: set_config(16'h7FFF, 16'h7FFF, 16'($urandom_range(100, 600)), 1'b1);
        default: set_config({1'($urandom), 15'(s)},
                            {1'($urandom), 15'($urandom_range(s, 40))},
                            16'($urandom_range(100, 600)), 1'b0);
      endcase
      repeat (195) random_item();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS button_press_classifier");
    end else begin
      $display("FAIL button_press_classifier");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL button_press_classifier");
    $finish;
  end

endmodule
